[src/mcf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcf_pkg: shared types and constants of the multichannel comb filter
// Field widths, register codes, reset values and arithmetic constants.
// ---------------------------------------------------------------------------
package mcf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 16;
  localparam int DLEN_W    = 13;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int RND_SHIFT = 15;

  localparam int DEF_MAX_DELAY = 4096;
  localparam int DEF_CHANNELS  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DGAIN  = 4'd3;

  typedef enum logic {
    MODE_FF = 1'b0,
    MODE_FB = 1'b1
  } mode_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } mcf_state_t;

  localparam logic signed [COEF_W-1:0] RST_GAIN  = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_DGAIN = 16'sd32767;

  localparam logic signed [ACC_W-1:0] RND_HALF = 42'sd16384;
  localparam logic signed [ACC_W-1:0] SAT_MAX  = 42'sd8388607;
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -42'sd8388608;
  localparam logic signed [SAMPLE_W-1:0] Y_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] Y_MIN = 24'sh800000;

endpackage

[src/multichannel_comb_filter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multichannel_comb_filter: feedforward / feedback comb on Q1.23 audio
// Per-channel circular delay lines in one synchronous memory, three-stage
// read / multiply / round-and-write pipeline with forwarding.
// ---------------------------------------------------------------------------
//  channel | direction | beat contents
//  in_     | slave     | tdata: sample_in[23:0]; tuser: channel[0]
//  out_    | master    | tdata: sample_out[23:0]
//  cfg_    | slave     | cfg_index selects register, cfg_data[15:0] value
//
//  One sample per cycle while no feedback hold or out_tready stall intervenes;
//  an in_ beat passes the p1, p2 and output registers before out_tvalid rises.
//  Feedback mode with delay 1 on one channel: a sample waits in stage 1 until
//  the previous sample has left stage 2, as it needs that sample's stored output.
//  After reset the delay memory is swept to zero, one entry a cycle, over all
//  CHANNELS * 2**clog2(MAX_DELAY) entries (8192 by default); in_tready is low.
//  out_tready low holds the output beat; earlier stages close their bubbles.
// ---------------------------------------------------------------------------
module multichannel_comb_filter #(
  parameter int MAX_DELAY = mcf_pkg::DEF_MAX_DELAY,
  parameter int CHANNELS  = mcf_pkg::DEF_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mcf_pkg::SAMPLE_W-1:0]   in_tdata,   // [23:0] sample_in
  input  logic [0:0]                     in_tuser,   // [0] channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mcf_pkg::SAMPLE_W-1:0]   out_tdata,  // [23:0] sample_out
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcf_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import mcf_pkg::*;

  localparam int AW    = $clog2(MAX_DELAY);
  localparam int DW    = AW + 1;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS << AW;
  localparam int MW    = $clog2(DEPTH);
  localparam int LW    = (DW > DLEN_W) ? DW : DLEN_W;
  localparam logic [MW-1:0] CLR_LAST = MW'(DEPTH - 1);
  localparam logic [AW-1:0] POS_LAST = AW'(MAX_DELAY - 1);

  // configuration
  mode_t                     mode_r;
  logic [DW-1:0]             dly_r;
  logic signed [COEF_W-1:0]  gain_r;
  logic signed [COEF_W-1:0]  dgain_r;
  logic [LW-1:0]             dl_ext;
  logic [DW-1:0]             dly_cfg;

  // clearing sweep
  mcf_state_t                state_r, state_nxt;
  logic [MW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic                      clearing;

  // write positions
  logic [AW-1:0]             wp_r [CHANNELS];
  logic [CW-1:0]             ch_in;
  logic [AW-1:0]             wp_in, wp_inc, rp_in;
  logic [DW-1:0]             wp_ext;
  logic [MW-1:0]             rd_addr, wr_addr_in;

  // delay memory
  logic [SAMPLE_W-1:0]       mem [DEPTH];
  logic [SAMPLE_W-1:0]       rd_data_r;
  logic                      mem_we;
  logic [MW-1:0]             mem_wa;
  logic [SAMPLE_W-1:0]       mem_wd;

  // pipeline
  logic                      p1_valid_r, p2_valid_r, out_valid_r;
  logic signed [SAMPLE_W-1:0] p1_x_r, p2_x_r;
  logic [MW-1:0]             p1_wa_r, p1_ra_r, p2_wa_r;
  logic signed [PROD_W-1:0]  p2_pa_r, p2_pb_r;
  logic [SAMPLE_W-1:0]       out_data_r;
  logic                      wb_valid_r;
  logic [MW-1:0]             wb_addr_r;
  logic [SAMPLE_W-1:0]       wb_data_r;

  logic                      accept, move2, p2_free, hz1, p1_adv, p1_load;
  logic                      fwd_p2, fwd_wb;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [COEF_W-1:0]  coef_a;
  logic signed [ACC_W-1:0]   acc, acc_sh;
  logic signed [SAMPLE_W-1:0] y;
  logic [SAMPLE_W-1:0]       stored;

  assign cfg_ready = 1'b1;

  // clamp delay length to 1..MAX_DELAY at write time
  always_comb begin
    dl_ext = LW'(cfg_data[DLEN_W-1:0]);
    if (dl_ext == '0) begin
      dly_cfg = DW'(1);
    end else if (dl_ext > LW'(MAX_DELAY)) begin
      dly_cfg = DW'(MAX_DELAY);
    end else begin
      dly_cfg = DW'(dl_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FB;
      dly_r   <= DW'(1);
      gain_r  <= RST_GAIN;
      dgain_r <= RST_DGAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_MODE:  mode_r  <= mode_t'(cfg_data[0]);
        CFG_IDX_DELAY: dly_r   <= dly_cfg;
        CFG_IDX_GAIN:  gain_r  <= cfg_data;
        CFG_IDX_DGAIN: dgain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing sequencer
  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // handshake and stage movement
  assign move2   = p2_valid_r && (!out_valid_r || out_tready);
  assign p2_free = !p2_valid_r || move2;
  // feedback: hold until the older write of the same entry has landed
  assign hz1     = (mode_r == MODE_FB) && p1_valid_r && p2_valid_r && (p1_ra_r == p2_wa_r);
  assign p1_adv  = p2_free && !hz1;
  assign p1_load = !p1_valid_r || p1_adv;
  assign in_tready = !clearing && p1_load;
  assign accept    = in_tvalid && in_tready;

  // address generation
  assign ch_in  = (CHANNELS == 1) ? '0 : CW'(in_tuser);
  assign wp_in  = wp_r[ch_in];
  assign wp_inc = (wp_in == POS_LAST) ? '0 : wp_in + 1'b1;
  assign wp_ext = {1'b0, wp_in};

  always_comb begin
    if (wp_ext >= dly_r) begin
      rp_in = AW'(wp_ext - dly_r);
    end else begin
      rp_in = AW'(wp_ext + DW'(MAX_DELAY) - dly_r);
    end
  end

  assign rd_addr    = MW'({ch_in, rp_in});
  assign wr_addr_in = MW'({ch_in, wp_in});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i] <= '0;
      end
    end else if (accept) begin
      wp_r[ch_in] <= wp_inc;
    end
  end

  // delay memory: one write port, one registered read port
  assign mem_we = clearing || move2;
  assign mem_wa = clearing ? clr_cnt_r : p2_wa_r;
  assign mem_wd = clearing ? '0 : stored;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // stage 1: pick the newest copy of the delayed sample, multiply
  assign fwd_p2  = p2_valid_r && (mode_r == MODE_FF) && (p2_wa_r == p1_ra_r);
  assign fwd_wb  = wb_valid_r && (wb_addr_r == p1_ra_r);
  assign delayed = fwd_p2 ? p2_x_r : (fwd_wb ? wb_data_r : rd_data_r);
  assign coef_a  = (mode_r == MODE_FB) ? gain_r : dgain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (p1_load) begin
      p1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_x_r  <= in_tdata;
      p1_wa_r <= wr_addr_in;
      p1_ra_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (p2_free) begin
      p2_valid_r <= p1_valid_r && !hz1;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_free && p1_valid_r && !hz1) begin
      p2_x_r  <= p1_x_r;
      p2_wa_r <= p1_wa_r;
      p2_pa_r <= p1_x_r * coef_a;
      p2_pb_r <= delayed * gain_r;
    end
  end

  // stage 2: sum (difference in feedback mode), round to Q1.23, saturate, write back
  always_comb begin
    if (mode_r == MODE_FB) begin
      acc = ACC_W'(p2_pa_r) - ACC_W'(p2_pb_r) + RND_HALF;
    end else begin
      acc = ACC_W'(p2_pa_r) + ACC_W'(p2_pb_r) + RND_HALF;
    end
    acc_sh = acc >>> RND_SHIFT;
    if (acc_sh > SAT_MAX) begin
      y = Y_MAX;
    end else if (acc_sh < SAT_MIN) begin
      y = Y_MIN;
    end else begin
      y = acc_sh[SAMPLE_W-1:0];
    end
  end

  assign stored = (mode_r == MODE_FB) ? y : p2_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (move2) begin
        wb_valid_r <= 1'b1;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= p2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      wb_addr_r  <= p2_wa_r;
      wb_data_r  <= stored;
      out_data_r <= y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_empty_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!p1_valid_r && !p2_valid_r && !out_valid_r))
    else $error("pipeline busy during memory clear");

  a_hold_on_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    hz1 |=> (p1_valid_r && $stable(p1_ra_r) && $stable(p1_x_r)))
    else $error("item left stage 1 before its entry was written");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> ((p1_ra_r[AW-1:0] <= POS_LAST) && (p1_wa_r[AW-1:0] <= POS_LAST)))
    else $error("delay line position out of range");

  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing) |-> ($past(clr_cnt_r) == CLR_LAST))
    else $error("memory clear ended early");
`endif

endmodule
